@@ hw/rtl/aob_pkg.sv @@
`default_nettype none
package aob_pkg;

    localparam int CH_W       = 8;
    localparam int DEN_W      = 16;
    localparam int REM_W      = 24;
    localparam int LANES      = 4;
    localparam int QUO_BITS   = CH_W;
    localparam int FRONT_STAGES = 2;
    localparam int PIPE_DEPTH = FRONT_STAGES + QUO_BITS;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    // lane assignment inside the divider chain
    localparam int LANE_ALPHA = 0;
    localparam int LANE_RED   = 1;
    localparam int LANE_GREEN = 2;
    localparam int LANE_BLUE  = 3;

    localparam logic [CH_W-1:0]  CH_MAX    = 8'd255;
    localparam logic [DEN_W-1:0] ALPHA_DIV = 16'd255;

    typedef struct packed {
        logic [CH_W-1:0] bg_alpha;
        logic [CH_W-1:0] bg_red;
        logic [CH_W-1:0] bg_green;
        logic [CH_W-1:0] bg_blue;
        logic [CH_W-1:0] fg_alpha;
        logic [CH_W-1:0] fg_red;
        logic [CH_W-1:0] fg_green;
        logic [CH_W-1:0] fg_blue;
    } in_pix_t;

    typedef struct packed {
        logic [CH_W-1:0] out_alpha;
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
    } out_pix_t;

    // weights and raw channels after the first front stage
    typedef struct packed {
        logic [DEN_W-1:0]          fw;
        logic [DEN_W-1:0]          bw;
        logic [2:0][CH_W-1:0]      fc;
        logic [2:0][CH_W-1:0]      bc;
    } wgt_t;

    // state handed from one division cell to the next
    typedef struct packed {
        logic [LANES-1:0][REM_W-1:0] rem;
        logic [LANES-1:0][CH_W-1:0]  quo;
        logic [DEN_W-1:0]            den;
        logic                        zero;
    } div_t;

endpackage
`default_nettype wire

@@ hw/rtl/alpha_over_blend.sv @@
`default_nettype none
// Source-over compositing of one RGBA8888 foreground pixel onto a background pixel.
// One pixel is accepted per clock while the output is not stalled. Each pixel passes
// through two front stages that form the weights and numerators, then a row of
// eight division cells that resolve one quotient bit per cell for the alpha and the
// three color lanes. Each stage holds its transaction while downstream stalls, so
// empty stages keep filling when the output is not taken. Color channels read 0
// when both alphas are 0.
module alpha_over_blend (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             src_valid,
    output logic                  src_ready,
    input  wire aob_pkg::in_pix_t src_pixel,
    output logic                  dst_valid,
    input  wire logic             dst_ready,
    output aob_pkg::out_pix_t     dst_pixel
);
    import aob_pkg::*;

    logic [QUO_BITS:0] chain_valid;
    logic [QUO_BITS:0] chain_ready;
    div_t              chain_data [QUO_BITS+1];
    div_t              last;
    logic [CNT_W-1:0]  inflight_reg;
    logic [CNT_W-1:0]  inflight_next;

    aob_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (src_valid),
        .up_ready (src_ready),
        .up       (src_pixel),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0]),
        .dn       (chain_data[0])
    );

    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_cell
        aob_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .up       (chain_data[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1]),
            .dn       (chain_data[i+1])
        );
    end

    assign last                  = chain_data[QUO_BITS];
    assign chain_ready[QUO_BITS] = dst_ready;
    assign dst_valid             = chain_valid[QUO_BITS];

    always_comb
    begin
        dst_pixel.out_alpha = last.quo[LANE_ALPHA];
        dst_pixel.out_red   = last.zero ? '0 : last.quo[LANE_RED];
        dst_pixel.out_green = last.zero ? '0 : last.quo[LANE_GREEN];
        dst_pixel.out_blue  = last.zero ? '0 : last.quo[LANE_BLUE];
    end

    // transactions in flight, for checking only
    always_comb
    begin
        inflight_next = inflight_reg;
        if (src_valid && src_ready)
            inflight_next = inflight_next + 1'b1;
        if (dst_valid && dst_ready)
            inflight_next = inflight_next - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more transactions in flight than pipeline stages");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg == '0) |-> src_ready)
        else $error("empty pipeline refuses input");

    a_valid_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> (inflight_reg != '0))
        else $error("result presented with nothing in flight");

endmodule
`default_nettype wire

@@ hw/rtl/aob_front.sv @@
`default_nettype none
module aob_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            up_valid,
    output logic                 up_ready,
    input  wire aob_pkg::in_pix_t up,
    output logic                 dn_valid,
    input  wire logic            dn_ready,
    output aob_pkg::div_t        dn
);
    import aob_pkg::*;

    logic  a_valid_reg;
    wgt_t  a_reg;
    wgt_t  a_next;
    logic  a_ready;
    logic  b_valid_reg;
    div_t  b_reg;
    div_t  b_next;

    // stage a: foreground and background weights
    always_comb
    begin
        a_next.fw = DEN_W'(up.fg_alpha) * DEN_W'(CH_MAX);
        a_next.bw = DEN_W'(up.bg_alpha) * DEN_W'(CH_MAX - up.fg_alpha);
        a_next.fc = {up.fg_red, up.fg_green, up.fg_blue};
        a_next.bc = {up.bg_red, up.bg_green, up.bg_blue};
    end

    // stage b: numerators and denominator
    always_comb
    begin
        logic [DEN_W:0]   den_sum;
        logic [REM_W-1:0] pf;
        logic [REM_W-1:0] pb;
        b_next  = '0;
        den_sum = {1'b0, a_reg.fw} + {1'b0, a_reg.bw};
        b_next.den  = den_sum[DEN_W-1:0];
        b_next.zero = (den_sum[DEN_W-1:0] == '0);
        b_next.rem[LANE_ALPHA] = REM_W'(den_sum[DEN_W-1:0]);
        for (int c = 0; c < 3; c++)
        begin
            pf = REM_W'(a_reg.fc[2-c]) * REM_W'(a_reg.fw);
            pb = REM_W'(a_reg.bc[2-c]) * REM_W'(a_reg.bw);
            b_next.rem[LANE_RED + c] = pf + pb;
        end
    end

    assign a_ready  = !b_valid_reg || dn_ready;
    assign up_ready = !a_valid_reg || a_ready;
    assign dn_valid = b_valid_reg;
    assign dn       = b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
                a_valid_reg <= up_valid;
            if (a_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            a_reg <= a_next;
        if (a_valid_reg && a_ready)
            b_reg <= b_next;
    end

endmodule
`default_nettype wire

@@ hw/rtl/aob_div_cell.sv @@
`default_nettype none
module aob_div_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          up_valid,
    output logic               up_ready,
    input  wire aob_pkg::div_t up,
    output logic               dn_valid,
    input  wire logic          dn_ready,
    output aob_pkg::div_t      dn
);
    import aob_pkg::*;

    logic valid_reg;
    div_t data_reg;
    div_t data_next;

    // one restoring step per lane: compare against the divisor placed seven bits up, subtract if it fits, shift left
    always_comb
    begin
        logic [REM_W-1:0] dsh;
        logic [REM_W-1:0] r;
        logic             qbit;
        data_next = up;
        for (int l = 0; l < LANES; l++)
        begin
            if (l == LANE_ALPHA)
                dsh = {1'b0, ALPHA_DIV, 7'b0};
            else
                dsh = {1'b0, up.den, 7'b0};
            qbit = (up.rem[l] >= dsh);
            r    = qbit ? (up.rem[l] - dsh) : up.rem[l];
            data_next.rem[l] = {r[REM_W-2:0], 1'b0};
            data_next.quo[l] = {up.quo[l][CH_W-2:0], qbit};
        end
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

@@ bench/alpha_over_blend_tb.sv @@
`timescale 1ns / 1ps

module alpha_over_blend_tb;

    import aob_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_ITEMS = 650;
    localparam int          DIR_N        = 18;
    localparam int          PRINT_CAP    = 100;

    // one row of stimulus; res is only used when typed is set
    typedef struct packed {
        in_pix_t  pix;
        logic     typed;
        out_pix_t res;
    } dir_row_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     src_valid = 1'b0;
    logic     src_ready;
    in_pix_t  src_pixel = '0;
    logic     dst_valid;
    logic     dst_ready = 1'b0;
    out_pix_t dst_pixel;

    dir_row_t    dir_rows [DIR_N];
    dir_row_t    staged_rows [$];
    out_pix_t    owed_pixels [$];
    bit          no_stall      = 1'b0;
    int unsigned cycles        = 0;
    int          fail_count    = 0;
    int          printed       = 0;
    int          checked_count = 0;
    int          clear_count   = 0;
    string       lane_name [4] = '{"blue", "green", "red", "alpha"};

    alpha_over_blend dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_pixel (src_pixel),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_pixel (dst_pixel)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still owed", $time, owed_pixels.size());
            $display("alpha_over_blend verification failed");
            $finish;
        end
    end

    // source over in exact integer math, truncating division
    function automatic out_pix_t blend_over(in_pix_t p);
        int unsigned fw;
        int unsigned bw;
        int unsigned den;
        out_pix_t    r;
        fw          = p.fg_alpha * 255;
        bw          = p.bg_alpha * (255 - p.fg_alpha);
        den         = fw + bw;
        r.out_alpha = 8'(den / 255);
        if (den == 0)
        begin
            r.out_red   = '0;
            r.out_green = '0;
            r.out_blue  = '0;
        end
        else
        begin
            r.out_red   = 8'((p.fg_red   * fw + p.bg_red   * bw) / den);
            r.out_green = 8'((p.fg_green * fw + p.bg_green * bw) / den);
            r.out_blue  = 8'((p.fg_blue  * fw + p.bg_blue  * bw) / den);
        end
        return r;
    endfunction

    // alphas lean toward the ends, where the weights degenerate
    function automatic logic [7:0] pick_alpha();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return 8'd0;
        else if (roll < 30)
            return 8'd255;
        else if (roll < 36)
            return 8'($urandom_range(1, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_channel();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return 8'd0;
        else if (roll < 16)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic in_pix_t random_pixel();
        in_pix_t p;
        p.bg_alpha = pick_alpha();
        p.bg_red   = pick_channel();
        p.bg_green = pick_channel();
        p.bg_blue  = pick_channel();
        p.fg_alpha = pick_alpha();
        p.fg_red   = pick_channel();
        p.fg_green = pick_channel();
        p.fg_blue  = pick_channel();
        return p;
    endfunction

    // called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_pixel(dir_row_t row);
        while (!no_stall && $urandom_range(0, 99) < 24)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_pixel <= row.pix;
        staged_rows.push_back(row);
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
    endtask

    always @(posedge clk)
        dst_ready <= no_stall || ($urandom_range(0, 99) >= 24);

    always @(posedge clk)
    begin : result_check
        dir_row_t                row;
        out_pix_t                want;
        logic [3:0][CH_W-1:0]    w;
        logic [3:0][CH_W-1:0]    g;
        if (rst_n)
        begin
            if (src_valid && src_ready)
            begin
                row  = staged_rows.pop_front();
                want = row.typed ? row.res : blend_over(src_pixel);
                owed_pixels.push_back(want);
                if (src_pixel.bg_alpha == 0 && src_pixel.fg_alpha == 0)
                    clear_count++;
            end
            if (dst_valid && dst_ready)
            begin
                if (owed_pixels.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected transaction, got %h", $time, dst_pixel);
                end
                else
                begin
                    want = owed_pixels.pop_front();
                    w    = want;
                    g    = dst_pixel;
                    checked_count++;
                    for (int k = 3; k >= 0; k--)
                    begin
                        if (g[k] !== w[k])
                        begin
                            fail_count++;
                            if (printed < PRINT_CAP)
                                $display("%0t: %s mismatch, expected %0d got %0d",
                                         $time, lane_name[k], w[k], g[k]);
                            printed++;
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        // pixel columns: bg a r g b, fg a r g b; result: a r g b
        dir_rows = '{
            '{64'h00_00_00_00_00_00_00_00, 1'b1, 32'h00_00_00_00},
            '{64'h00_FF_FF_FF_00_FF_FF_FF, 1'b1, 32'h00_00_00_00},
            '{64'h80_99_AA_BB_FF_0C_22_38, 1'b1, 32'hFF_0C_22_38},
            '{64'hFF_01_02_03_00_FE_FD_FC, 1'b1, 32'hFF_01_02_03},
            '{64'h40_AA_55_FF_00_12_34_56, 1'b1, 32'h40_AA_55_FF},
            '{64'hFF_FF_FF_FF_FF_FF_FF_FF, 1'b1, 32'hFF_FF_FF_FF},
            '{64'hFF_FF_FF_FF_FF_00_00_00, 1'b1, 32'hFF_00_00_00},
            '{64'h00_FF_FF_FF_FF_00_00_00, 1'b1, 32'hFF_00_00_00},
            '{64'h00_33_44_55_01_FF_80_7F, 1'b1, 32'h01_FF_80_7F},
            '{64'h01_FF_80_7F_00_11_22_33, 1'b1, 32'h01_FF_80_7F},
            '{64'h80_FF_00_80_80_00_FF_80, 1'b0, 32'h0},
            '{64'hFF_FF_FF_FF_01_00_00_00, 1'b0, 32'h0},
            '{64'hFF_00_00_00_FE_FF_FF_FF, 1'b0, 32'h0},
            '{64'h01_FF_FF_FF_01_00_00_00, 1'b0, 32'h0},
            '{64'hAA_AA_AA_AA_55_55_55_55, 1'b0, 32'h0},
            '{64'h55_55_55_55_AA_AA_AA_AA, 1'b0, 32'h0},
            '{64'hFE_7F_80_01_7F_80_7F_FE, 1'b0, 32'h0},
            '{64'h7F_FF_00_FF_80_00_FF_00, 1'b0, 32'h0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
            send_pixel(dir_rows[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // a long back-to-back stretch with both sides always ready
            no_stall = (i >= 260 && i < 400);
            send_pixel('{random_pixel(), 1'b0, 32'h0});
        end
        no_stall = 1'b0;
        src_valid <= 1'b0;

        while (staged_rows.size() != 0 || owed_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);

        $display("%0d directed and %0d random pixels sent, %0d results compared",
                 DIR_N, RANDOM_ITEMS, checked_count);
        $display("%0d pixels had both alphas clear, %0d field mismatches",
                 clear_count, fail_count);
        if (fail_count == 0)
            $display("alpha_over_blend verification clean");
        else
            $display("alpha_over_blend verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/aob_pkg.sv
hw/rtl/aob_front.sv
hw/rtl/aob_div_cell.sv
hw/rtl/alpha_over_blend.sv
bench/alpha_over_blend_tb.sv
